/* hw/rtl/apq_pkg.sv */
// shared types, constants and helpers of the alert priority queue
`default_nettype none

package apq_pkg;

  localparam int unsigned PendingSlots = 4;
  localparam int unsigned IdxW = (PendingSlots > 1) ? $clog2(PendingSlots) : 1;
  localparam int unsigned CountW = $clog2(PendingSlots + 1);

  localparam logic [63:0] IdMax = '1;
  localparam logic [31:0] SkipMax = '1;

  typedef enum logic [1:0] {
    KIND_ENQUEUE = 2'd0,
    KIND_DISMISS = 2'd1,
    KIND_REMOVE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SRC_NONE     = 2'd0,
    SRC_ALARM    = 2'd1,
    SRC_TIMER    = 2'd2,
    SRC_INTERVAL = 2'd3
  } source_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_COALESCE,
    OP_APPEND,
    OP_DEL_IDX,
    OP_DEL_SRC
  } cell_op_e;

  typedef struct packed {
    logic [63:0] id;
    logic [63:0] occ;
    logic [31:0] skips;
    logic [1:0]  src;
    logic [1:0]  rsn;
    logic        rec;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t ent;
  } slot_t;

  typedef struct packed {
    logic            valid;
    logic [1:0]      prio;
    logic [63:0]     id;
    logic [IdxW-1:0] idx;
  } best_t;

  typedef struct packed {
    cell_op_e        op;
    logic [1:0]      key_src;
    logic [IdxW-1:0] idx;
    entry_t          ent;
  } cell_cmd_t;

  function automatic logic [1:0] prio_of(logic [1:0] src);
    logic [1:0] p;
    case (src)
      SRC_ALARM: p = 2'd3;
      SRC_TIMER: p = 2'd2;
      default:   p = 2'd1;
    endcase
    return p;
  endfunction

  function automatic logic [31:0] sat_add_skip(logic [31:0] have, logic [31:0] skipped);
    logic [33:0] sum;
    sum = {2'b00, have} + {2'b00, skipped} + 34'd1;
    return (sum > {2'b00, SkipMax}) ? SkipMax : sum[31:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/apq_cell.sv */
// one pending slot of the queue: holds an entry, coalesces, shifts, appends and ranks
`default_nettype none

module apq_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  apq_pkg::cell_cmd_t         cmd_i,
  input  logic [apq_pkg::IdxW-1:0]   idx_i,
  input  logic                       left_valid_i,
  input  logic                       left_del_i,
  input  apq_pkg::slot_t             right_i,
  input  apq_pkg::best_t             best_i,
  output apq_pkg::slot_t             slot_o,
  output logic                       del_o,
  output logic                       match_o,
  output apq_pkg::best_t             best_o
);
  import apq_pkg::*;

  slot_t      slot_q, slot_d;
  best_t      best_q, best_d;
  logic       target;
  logic [1:0] own_prio;
  logic       own_better;

  assign match_o = slot_q.valid && (slot_q.ent.src == cmd_i.key_src);
  assign target  = ((cmd_i.op == OP_DEL_IDX) && (idx_i == cmd_i.idx)) ||
                   ((cmd_i.op == OP_DEL_SRC) && match_o);
  // any target at or left of this cell pulls the right neighbor in
  assign del_o   = left_del_i || target;

  always_comb begin
    slot_d = slot_q;
    case (cmd_i.op)
      OP_COALESCE: begin
        if (match_o) begin
          slot_d.ent.occ   = cmd_i.ent.occ;
          slot_d.ent.skips = sat_add_skip(slot_q.ent.skips, cmd_i.ent.skips);
          slot_d.ent.rec   = 1'b1;
        end
      end
      OP_APPEND: begin
        if (!slot_q.valid && left_valid_i) begin
          slot_d.valid = 1'b1;
          slot_d.ent   = cmd_i.ent;
        end
      end
      OP_DEL_IDX, OP_DEL_SRC: begin
        if (del_o) begin
          slot_d = right_i;
        end
      end
      default: ;
    endcase
  end

  // ranking token moves one cell per cycle: priority first, then lower id
  assign own_prio   = prio_of(slot_q.ent.src);
  assign own_better = slot_q.valid &&
                      (!best_i.valid || (own_prio > best_i.prio) ||
                       ((own_prio == best_i.prio) && (slot_q.ent.id < best_i.id)));

  always_comb begin
    best_d = best_i;
    if (own_better) begin
      best_d.valid = 1'b1;
      best_d.prio  = own_prio;
      best_d.id    = slot_q.ent.id;
      best_d.idx   = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      best_q <= '0;
    end else begin
      slot_q <= slot_d;
      best_q <= best_d;
    end
  end

  assign slot_o = slot_q;
  assign best_o = best_q;

endmodule

`default_nettype wire

/* hw/rtl/alert_priority_queue_core.sv */
// top level of the alert priority queue: sequencer, active alert and cell chain
`default_nettype none

// Keeps one active alert and a row of pending slots, each slot a cell that
// can shift toward the head, take an appended word or coalesce in place.
// One word is worked at a time. An enqueue passes the execute state, then
// waits in the done state until the output is free; its result is then
// registered on the output and the sequencer goes back to idle, where the
// next word can be taken. A dismiss, or a remove that hits the active source,
// ranks the pending slots when any are held, passing a token along the cell
// chain, one cell a cycle; a remove then purges matching slots. A new word
// is accepted while the last result is still waiting on the output.
module alert_priority_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  source_i,
  input  logic [1:0]  reason_i,
  input  logic [63:0] occurrence_i,
  input  logic [31:0] skipped_i,
  input  logic        recovered_i,
  input  logic [63:0] alert_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic        active_valid_o,
  output logic [63:0] active_id_o,
  output logic [1:0]  active_source_o,
  output logic [1:0]  active_reason_o,
  output logic [63:0] active_occurrence_o,
  output logic [31:0] active_skips_o,
  output logic        active_recovered_o,
  output logic [2:0]  waiting_count_o
);
  import apq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_PICK,
    S_PURGE,
    S_DONE
  } state_e;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  src;
    logic [1:0]  rsn;
    logic [63:0] occ;
    logic [31:0] skipped;
    logic        rec;
    logic [63:0] aid;
  } req_t;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  entry_t            cur_q, cur_d;
  logic [63:0]       fresh_q, fresh_d;
  logic [CountW-1:0] count_q, count_d;
  logic              ok_q, ok_d;
  logic              purge_q, purge_d;
  logic [IdxW-1:0]   scan_q, scan_d;
  logic              out_valid_q, out_valid_d;
  logic              out_acc_q, out_acc_d;
  entry_t            out_ent_q, out_ent_d;
  logic [CountW-1:0] out_cnt_q, out_cnt_d;

  cell_cmd_t                cmd;
  entry_t                   new_ent;
  logic                     start_promote;
  logic                     any_match;
  logic [PendingSlots-1:0]  match_vec;
  logic [PendingSlots-1:0]  del_vec;
  logic [PendingSlots-1:0]  valid_vec;
  slot_t                    slots [PendingSlots];
  best_t                    bests [PendingSlots];
  best_t                    best_last;

  for (genvar g = 0; g < PendingSlots; g++) begin : g_cell
    logic  lv;
    logic  ld;
    best_t bi;
    slot_t ri;

    if (g == 0) begin : g_head
      assign lv = 1'b1;
      assign ld = 1'b0;
      assign bi = '0;
    end else begin : g_body
      assign lv = slots[g-1].valid;
      assign ld = del_vec[g-1];
      assign bi = bests[g-1];
    end

    if (g == PendingSlots - 1) begin : g_tail
      assign ri = '0;
    end else begin : g_inner
      assign ri = slots[g+1];
    end

    apq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .idx_i        (IdxW'(g)),
      .left_valid_i (lv),
      .left_del_i   (ld),
      .right_i      (ri),
      .best_i       (bi),
      .slot_o       (slots[g]),
      .del_o        (del_vec[g]),
      .match_o      (match_vec[g]),
      .best_o       (bests[g])
    );

    assign valid_vec[g] = slots[g].valid;
  end

  assign best_last = bests[PendingSlots-1];
  assign any_match = |match_vec;

  assign new_ent.id    = fresh_q;
  assign new_ent.occ   = req_q.occ;
  assign new_ent.skips = req_q.skipped;
  assign new_ent.src   = req_q.src;
  assign new_ent.rsn   = req_q.rsn;
  assign new_ent.rec   = req_q.rec;

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    cur_d         = cur_q;
    fresh_d       = fresh_q;
    count_d       = count_q;
    ok_d          = ok_q;
    purge_d       = purge_q;
    scan_d        = scan_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_acc_d     = out_acc_q;
    out_ent_d     = out_ent_q;
    out_cnt_d     = out_cnt_q;
    start_promote = 1'b0;
    cmd.op        = OP_NONE;
    cmd.key_src   = req_q.src;
    cmd.idx       = best_last.idx;
    cmd.ent       = new_ent;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d.kind    = kind_e'(kind_i);
          req_d.src     = source_i;
          req_d.rsn     = reason_i;
          req_d.occ     = occurrence_i;
          req_d.skipped = skipped_i;
          req_d.rec     = recovered_i;
          req_d.aid     = alert_id_i;
          state_d       = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_DONE;
        ok_d    = 1'b0;
        purge_d = 1'b0;
        case (req_q.kind)
          KIND_ENQUEUE: begin
            if (req_q.src != SRC_NONE) begin
              if (cur_q.src == req_q.src) begin
                cur_d.occ   = req_q.occ;
                cur_d.skips = sat_add_skip(cur_q.skips, req_q.skipped);
                cur_d.rec   = 1'b1;
                ok_d        = 1'b1;
              end else if (any_match) begin
                cmd.op = OP_COALESCE;
                ok_d   = 1'b1;
              end else if (fresh_q != IdMax) begin
                ok_d    = 1'b1;
                fresh_d = fresh_q + 64'd1;
                if (cur_q.src == SRC_NONE) begin
                  cur_d = new_ent;
                end else begin
                  cmd.op = OP_APPEND;
                  // preempt: old active goes to the tail, dropped if the row is full
                  if (prio_of(req_q.src) > prio_of(cur_q.src)) begin
                    cmd.ent = cur_q;
                    cur_d   = new_ent;
                  end
                  if (count_q != CountW'(PendingSlots)) begin
                    count_d = count_q + CountW'(1);
                  end
                end
              end
            end
          end
          KIND_DISMISS: begin
            if ((req_q.aid != 64'd0) && (cur_q.src != SRC_NONE) &&
                (cur_q.id == req_q.aid)) begin
              ok_d          = 1'b1;
              start_promote = 1'b1;
            end
          end
          KIND_REMOVE: begin
            if (req_q.src != SRC_NONE) begin
              ok_d    = 1'b1;
              purge_d = 1'b1;
              if (cur_q.src == req_q.src) begin
                start_promote = 1'b1;
              end else begin
                state_d = S_PURGE;
              end
            end
          end
          default: ;
        endcase

        if (start_promote) begin
          if (count_q == '0) begin
            cur_d   = '0;
            state_d = purge_d ? S_PURGE : S_DONE;
          end else begin
            scan_d  = '0;
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // token walks the cell chain from head to tail
        scan_d = scan_q + IdxW'(1);
        if (scan_q == IdxW'(PendingSlots - 1)) begin
          state_d = S_PICK;
        end
      end

      S_PICK: begin
        cur_d   = slots[best_last.idx].ent;
        cmd.op  = OP_DEL_IDX;
        count_d = count_q - CountW'(1);
        state_d = purge_q ? S_PURGE : S_DONE;
      end

      S_PURGE: begin
        cmd.op = OP_DEL_SRC;
        if (any_match) begin
          count_d = count_q - CountW'(1);
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_acc_d   = ok_q;
          out_ent_d   = cur_q;
          out_cnt_d   = count_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      cur_q       <= '0;
      fresh_q     <= 64'd1;
      count_q     <= '0;
      ok_q        <= 1'b0;
      purge_q     <= 1'b0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
      out_acc_q   <= 1'b0;
      out_ent_q   <= '0;
      out_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      cur_q       <= cur_d;
      fresh_q     <= fresh_d;
      count_q     <= count_d;
      ok_q        <= ok_d;
      purge_q     <= purge_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
      out_acc_q   <= out_acc_d;
      out_ent_q   <= out_ent_d;
      out_cnt_q   <= out_cnt_d;
    end
  end

  assign in_ready_o          = (state_q == S_IDLE);
  assign out_valid_o         = out_valid_q;
  assign accepted_o          = out_acc_q;
  assign active_valid_o      = (out_ent_q.src != SRC_NONE);
  assign active_id_o         = out_ent_q.id;
  assign active_source_o     = out_ent_q.src;
  assign active_reason_o     = out_ent_q.rsn;
  assign active_occurrence_o = out_ent_q.occ;
  assign active_skips_o      = out_ent_q.skips;
  assign active_recovered_o  = out_ent_q.rec;
  assign waiting_count_o     = 3'(out_cnt_q);

`ifndef ASSERT_OFF
  a_count_matches_cells : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("pending count disagrees with cell valid bits");

  a_no_pending_without_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q.src == SRC_NONE) |-> (count_q == '0))
    else $error("pending alerts with no active alert");

  a_fresh_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q != 64'd0)
    else $error("fresh id wrapped to zero");

  a_pick_has_winner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PICK) |-> best_last.valid)
    else $error("promotion without a ranked pending slot");
`endif

endmodule

`default_nettype wire
